// File: hdl/polynomial_inverse_bisection_macros.svh
// Assertion macros for the polynomial inverse block.
`ifndef POLYNOMIAL_INVERSE_BISECTION_MACROS_SVH
`define POLYNOMIAL_INVERSE_BISECTION_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PIB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PIB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/pib_pkg.sv
// Shared types and constants of the polynomial inverse block.
`timescale 1ns / 1ps

package pib_pkg;

    localparam int COEF_W     = 48;   // Q16.32 coefficient
    localparam int CUR_W      = 32;   // Q16.16 current
    localparam int CURQ_W     = 48;   // current moved to .32
    localparam int FIELD_W    = 24;   // Q8.16 field
    localparam int FRAC_W     = 16;
    localparam int ORDER_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_COEF   = 6;
    localparam int COEF_IDX_W = 3;
    localparam int ACC_W      = 63;   // Horner accumulator, +-(2^62 - 1)
    localparam int MAG_W      = 62;
    localparam int WIDE_W     = 64;
    localparam int NUM_W      = 49;   // current minus c0
    localparam int DMAG_W     = 48;   // divider operand magnitude
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 24;
    localparam int MUL_P_W    = 56;
    localparam int PH_W       = 54;   // upper partial product

    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [CUR_W-1:0]   t_cur;
    typedef logic        [FIELD_W-1:0] t_field;
    typedef logic                      t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 3'd7;

    localparam logic [ORDER_W-1:0] ORDER_NONE   = 3'd0;
    localparam logic [ORDER_W-1:0] ORDER_LIN_LO = 3'd1;
    localparam logic [ORDER_W-1:0] ORDER_LIN_HI = 3'd2;

    localparam t_status STAT_OK        = 1'b0;
    localparam t_status STAT_BAD_ORDER = 1'b1;

    localparam logic [MAG_W-1:0] ACC_LIM       = {MAG_W{1'b1}};
    localparam t_field           MAX_FIELD_RST = {FIELD_W{1'b1}};

    typedef struct packed {
        logic              start;
        logic [DMAG_W-1:0] num_mag;
        logic [DMAG_W-1:0] den_mag;
    } t_div_req;

    typedef struct packed {
        logic   done;
        logic   ovf;
        t_field quo;
    } t_div_rsp;

endpackage

// File: hdl/pib_if.sv
// Request and result channel interfaces of the polynomial inverse block.
`timescale 1ns / 1ps

interface pib_in_if import pib_pkg::*; ();
    logic valid;
    logic ready;
    t_cur target_current;

    modport source (output valid, output target_current, input ready);
    modport sink (input valid, input target_current, output ready);
endinterface

interface pib_out_if import pib_pkg::*; ();
    logic    valid;
    logic    ready;
    t_field  field_out;
    t_status status;

    modport source (output valid, output field_out, output status, input ready);
    modport sink (input valid, input field_out, input status, output ready);
endinterface

// File: hdl/pib_mul.sv
// Shared 32x24 unsigned multiplier with registered product.
`timescale 1ns / 1ps

module pib_mul import pib_pkg::*; (
    input  logic               i_clk,
    input  logic [MUL_A_W-1:0] i_a,
    input  logic [MUL_B_W-1:0] i_b,
    output logic [MUL_P_W-1:0] o_p
);

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: hdl/pib_div.sv
// Radix-2 restoring divider for the line solve, flagging quotient overflow.
`timescale 1ns / 1ps

module pib_div import pib_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} t_dstate;

    localparam int CNT_W = $clog2(FIELD_W);
    localparam int PRE_W = FIELD_W - FRAC_W;   // integer quotient bits

    t_dstate           r_state;
    logic [DMAG_W-1:0] r_num;
    logic [DMAG_W-1:0] r_den;
    logic [DMAG_W-1:0] r_rem;
    t_field            r_low;
    t_field            r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic              r_ovf;

    logic              too_big;
    logic [DMAG_W+1:0] trial;

    // quotient would reach 2^24: numerator >= divisor * 2^8
    assign too_big = {{PRE_W{1'b0}}, r_num} >= {r_den, {PRE_W{1'b0}}};
    assign trial   = {1'b0, r_rem, r_low[FIELD_W-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= i_req.num_mag;
                        r_den   <= i_req.den_mag;
                        r_state <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    r_ovf <= too_big;
                    r_rem <= DMAG_W'(r_num >> PRE_W);
                    r_low <= {r_num[PRE_W-1:0], {FRAC_W{1'b0}}};
                    r_cnt <= CNT_W'(FIELD_W - 1);
                    if (too_big) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (trial[DMAG_W+1]) begin
                        r_rem <= {r_rem[DMAG_W-2:0], r_low[FIELD_W-1]};
                    end else begin
                        r_rem <= trial[DMAG_W-1:0];
                    end
                    r_quo <= {r_quo[FIELD_W-2:0], ~trial[DMAG_W+1]};
                    r_low <= {r_low[FIELD_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quo  = r_quo;

endmodule

// File: hdl/polynomial_inverse_bisection.sv
// Top level: inverse of a quintic calibration polynomial by bisection, or by division
// for a line. A bisection step makes five Horner passes through the one 32x24 multiplier,
// each a sign/magnitude step, upper and lower multiply, combine and add; a full 24-bit
// range needs 24 steps. Line solve uses the divider, one quotient bit a cycle; bad order
// goes straight to the result. One request at a time, the next taken the cycle after the
// result is handed over, even while the last result still waits at the output.
`timescale 1ns / 1ps
`include "polynomial_inverse_bisection_macros.svh"

module polynomial_inverse_bisection import pib_pkg::*; #(
    parameter int MAX_ITERATIONS = 100,
    parameter int TOLERANCE_LSB  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    pib_in_if.sink               i_req,
    pib_out_if.source            o_res
);

    // Reset (synchronous, active low) idles the sequencer and restores register defaults.

    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [ITER_W-1:0]  ITER_LAST = ITER_W'(MAX_ITERATIONS);
    // stop once the bracket is narrower than twice the tolerance
    localparam logic [FIELD_W:0]   TOL_SPAN  = (FIELD_W + 1)'(2 * TOLERANCE_LSB);
    localparam logic signed [WIDE_W-1:0] LIM_W = signed'(WIDE_W'(ACC_LIM));

    typedef enum logic [3:0] {
        S_IDLE, S_MID, S_ABS, S_MULH, S_MULL, S_COMB, S_ADD, S_CMP,
        S_LIN_DIV, S_LIN_WAIT, S_DONE
    } t_state;

    // ---- configuration registers ----
    t_coef               r_coef [NUM_COEF];
    logic [ORDER_W-1:0]  r_order;
    t_field              r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
            r_order <= ORDER_NONE;
            r_max   <= MAX_FIELD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                CFG_MAX:   r_max   <= i_cfg_data[FIELD_W-1:0];
                default:   r_coef[i_cfg_idx] <= i_cfg_data;   // coefficients 0..5
            endcase
        end
    end

    // ---- sequencer and datapath registers ----
    t_state                    r_state;
    logic signed [CURQ_W-1:0]  r_cur;        // current in .32
    logic                      r_sref_pos;
    logic                      r_sref_neg;
    logic signed [NUM_W-1:0]   r_num;
    t_field                    r_lo;
    t_field                    r_hi;
    t_field                    r_mid;
    logic [ITER_W-1:0]         r_iter;
    logic [COEF_IDX_W-1:0]     r_k;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic [PH_W-1:0]           r_ph;
    logic [MAG_W-1:0]          r_res;
    t_field                    r_rfield;
    t_status                   r_rstat;
    logic                      r_ovalid;
    t_field                    r_ofield;
    t_status                   r_ostat;

    logic                      req_take;
    logic signed [CURQ_W-1:0]  cur_in;
    logic signed [NUM_W-1:0]   sref_in;
    logic signed [NUM_W-1:0]   num_in;
    logic [FIELD_W:0]          mid_sum;
    t_field                    mid_val;
    t_field                    mid_span;
    logic [MUL_A_W-1:0]        mul_a;
    logic [MUL_P_W-1:0]        mul_p;
    logic                      ph_ovf;
    logic [ACC_W-1:0]          prod_raw;
    logic [MAG_W-1:0]          n_res;
    logic signed [WIDE_W-1:0]  coef_k;
    logic signed [WIDE_W-1:0]  res_x;
    logic signed [WIDE_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]   n_acc;
    logic [MAG_W-1:0]          n_mag;
    logic signed [WIDE_W-1:0]  resid;
    logic                      resid_zero;
    logic                      move_lo;
    logic                      lin_trivial;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    t_field                    lin_field;

    assign req_take = i_req.valid && i_req.ready;
    assign cur_in   = {i_req.target_current, {FRAC_W{1'b0}}};
    assign sref_in  = NUM_W'(r_coef[0]) - NUM_W'(cur_in);
    assign num_in   = NUM_W'(cur_in) - NUM_W'(r_coef[0]);

    assign mid_sum  = (FIELD_W + 1)'(r_lo) + (FIELD_W + 1)'(r_hi);
    assign mid_val  = mid_sum[FIELD_W:1];
    assign mid_span = r_hi - r_lo;

    // shared multiplier: upper magnitude word first, then the lower one
    assign mul_a = (r_state == S_MULH) ? MUL_A_W'(r_mag[MAG_W-1:MUL_A_W])
                                       : r_mag[MUL_A_W-1:0];

    pib_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_mid),
        .o_p   (mul_p)
    );

    // |acc| * b / 2^16, truncated, saturated at 2^62 - 1
    assign ph_ovf   = |r_ph[PH_W-1:MAG_W-FRAC_W];
    assign prod_raw = ACC_W'({r_ph[MAG_W-FRAC_W-1:0], {FRAC_W{1'b0}}})
                    + ACC_W'(mul_p[MUL_P_W-1:FRAC_W]);
    assign n_res    = (ph_ovf || prod_raw[ACC_W-1]) ? ACC_LIM : prod_raw[MAG_W-1:0];

    // coefficient add with the product's sign folded in, then clamp
    assign coef_k  = WIDE_W'(r_coef[r_k]);
    assign res_x   = signed'(WIDE_W'(r_res));
    assign acc_sum = r_neg ? (coef_k - res_x) : (coef_k + res_x);
    assign n_acc   = (acc_sum > LIM_W)  ? ACC_W'(LIM_W)  :
                     (acc_sum < -LIM_W) ? ACC_W'(-LIM_W) : ACC_W'(acc_sum);

    assign n_mag = r_acc[ACC_W-1] ? MAG_W'(-r_acc) : MAG_W'(r_acc);

    // residual sign against the sign reference c0 - I
    assign resid      = WIDE_W'(r_acc) - WIDE_W'(r_cur);
    assign resid_zero = (resid == '0);
    assign move_lo    = (!resid[WIDE_W-1] && r_sref_pos) || (resid[WIDE_W-1] && r_sref_neg);

    // line solve: zero numerator or opposite signs give field 0
    assign lin_trivial = (r_num == '0) || (r_num[NUM_W-1] != r_coef[1][COEF_W-1]);
    assign div_req.start   = (r_state == S_LIN_DIV) && !lin_trivial;
    assign div_req.num_mag = r_num[NUM_W-1] ? DMAG_W'(-r_num) : DMAG_W'(r_num);
    assign div_req.den_mag = r_coef[1][COEF_W-1] ? DMAG_W'(-(NUM_W'(r_coef[1])))
                                                 : DMAG_W'(r_coef[1]);

    pib_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign lin_field = (div_rsp.ovf || (div_rsp.quo > r_max)) ? r_max : div_rsp.quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (o_res.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_cur      <= cur_in;
                        r_sref_pos <= !sref_in[NUM_W-1] && (sref_in != '0);
                        r_sref_neg <= sref_in[NUM_W-1];
                        r_num      <= num_in;
                        r_lo       <= '0;
                        r_hi       <= r_max;
                        r_iter     <= '0;
                        r_rstat    <= (r_order == ORDER_NONE) ? STAT_BAD_ORDER : STAT_OK;
                        if (r_order == ORDER_NONE) begin
                            r_rfield <= '0;
                            r_state  <= S_DONE;
                        end else if ((r_order inside {[ORDER_LIN_LO:ORDER_LIN_HI]})
                                     && (r_coef[1] != '0)) begin
                            r_state <= S_LIN_DIV;
                        end else begin
                            r_state <= S_MID;
                        end
                    end
                end
                S_MID: begin
                    if (r_iter == ITER_LAST) begin
                        r_rfield <= r_mid;          // step limit: keep last midpoint
                        r_state  <= S_DONE;
                    end else begin
                        r_mid <= mid_val;
                        if ({1'b0, mid_span} < TOL_SPAN) begin
                            r_rfield <= mid_val;
                            r_state  <= S_DONE;
                        end else begin
                            r_acc   <= ACC_W'(r_coef[NUM_COEF-1]);
                            r_k     <= COEF_IDX_W'(NUM_COEF - 2);
                            r_state <= S_ABS;
                        end
                    end
                end
                S_ABS: begin
                    r_neg   <= r_acc[ACC_W-1];
                    r_mag   <= n_mag;
                    r_state <= S_MULH;
                end
                S_MULH: r_state <= S_MULL;
                S_MULL: begin
                    r_ph    <= mul_p[PH_W-1:0];
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_res   <= n_res;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= n_acc;
                    if (r_k == '0) begin
                        r_state <= S_CMP;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_state <= S_ABS;
                    end
                end
                S_CMP: begin
                    if (resid_zero) begin
                        r_rfield <= r_mid;
                        r_state  <= S_DONE;
                    end else begin
                        if (move_lo) begin
                            r_lo <= r_mid;
                        end else begin
                            r_hi <= r_mid;
                        end
                        r_iter  <= r_iter + 1'b1;
                        r_state <= S_MID;
                    end
                end
                S_LIN_DIV: begin
                    if (lin_trivial) begin
                        r_rfield <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_LIN_WAIT;
                    end
                end
                S_LIN_WAIT: begin
                    if (div_rsp.done) begin
                        r_rfield <= lin_field;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || o_res.ready) begin
                        r_ofield <= r_rfield;
                        r_ostat  <= r_rstat;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.field_out = r_ofield;
    assign o_res.status    = r_ostat;

    // ---- assertions ----
    `PIB_ASSERT_NXT(a_busy_after_req, req_take, !i_req.ready, "ready straight after a request")
    `PIB_ASSERT_IMP(a_bad_order_zero,
                    o_res.valid && (o_res.status == STAT_BAD_ORDER),
                    o_res.field_out == '0,
                    "bad order result with nonzero field")
    `PIB_ASSERT_IMP(a_mid_bracketed,
                    r_state == S_CMP,
                    (r_mid >= r_lo) && (r_mid <= r_hi),
                    "midpoint outside bracket")

endmodule

// File: dv/polynomial_inverse_bisection_tb.sv
// Self-checking testbench for the quintic polynomial inverse (bisection) block.
`timescale 1ns / 1ps

module polynomial_inverse_bisection_tb import pib_pkg::*; ();

    // Build-time knobs, handed to the block so both sides agree.
    localparam int MAX_ITER = 100;
    localparam int TOL_LSB  = 1;

    // Largest gap with no request or result moving before the run is abandoned.
    // This leaves ample room for stalls beyond one full-range bisection.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd0;
    localparam logic [ORDER_W-1:0]   ORDER_FULL = 3'd6;
    localparam logic [ORDER_W-1:0]   ORDER_OVER = 3'd7;   // past the last coefficient

    // Horner accumulator rails and the Q16.16 current range.
    localparam longint ACC_SAT = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam longint CUR_HI  = 64'sd2147483647;
    localparam longint CUR_LO  = -64'sd2147483648;

    typedef struct {
        t_field  field;
        t_status status;
    } t_solution;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0]    cfg_data;

    pib_in_if  req_ch ();
    pib_out_if res_ch ();

    polynomial_inverse_bisection #(
        .MAX_ITERATIONS (MAX_ITER),
        .TOLERANCE_LSB  (TOL_LSB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    // Our own copy of the calibration registers, kept in step with every write.
    t_coef  cal_coef [NUM_COEF];
    logic [ORDER_W-1:0] cal_order;
    t_field cal_max;

    t_cur      pending [$];        // currents not yet taken by the block
    t_solution solutions_due [$];  // fields owed, oldest first
    bit        req_busy;           // pending[0] is on the request channel
    bit        calm;               // no idling on either side while set
    int        mismatches;
    int        stall_cycles;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_acc(longint x);
        if (x > ACC_SAT) return ACC_SAT;
        if (x < -ACC_SAT) return -ACC_SAT;
        return x;
    endfunction

    // acc * b / 2^16, truncated towards zero, pinned at the accumulator rail.
    // Split into upper and lower 32-bit halves of |acc| as the hardware does.
    function automatic longint scale_by_field(longint acc, t_field b);
        bit        neg;
        bit [63:0] mag;
        bit [63:0] hi_part;
        bit [63:0] res;
        neg     = acc < 0;
        mag     = neg ? -acc : acc;
        hi_part = (mag >> 32) * 64'(b);
        if (hi_part >= (64'd1 << 46)) begin
            res = ACC_SAT;
        end else begin
            res = (hi_part << 16) + (((mag & 64'hFFFF_FFFF) * 64'(b)) >> 16);
            if (res > ACC_SAT) res = ACC_SAT;
        end
        return neg ? -$signed(res) : $signed(res);
    endfunction

    // P(b) in Q.32; always all six coefficients, whatever the order count says.
    function automatic longint horner(t_field b);
        longint acc;
        acc = longint'(cal_coef[5]);
        for (int k = 4; k >= 0; k--)
            acc = clamp_acc(scale_by_field(acc, b) + longint'(cal_coef[k]));
        return acc;
    endfunction

    // Straight-line shortcut: (I - c0) / c1, floored at 0 and capped at max_field.
    function automatic t_field solve_line(longint cur_q);
        longint    num;
        longint    den;
        bit [63:0] nm;
        bit [63:0] dm;
        bit [63:0] qi;
        bit [63:0] rem;
        bit [63:0] q;
        num = cur_q - longint'(cal_coef[0]);
        den = longint'(cal_coef[1]);
        if (num == 0) return '0;
        if ((num < 0) != (den < 0)) return '0;
        nm  = num < 0 ? -num : num;
        dm  = den < 0 ? -den : den;
        qi  = nm / dm;
        rem = nm % dm;
        if (qi >= (64'd1 << FIELD_W)) return cal_max;
        q = (qi << FRAC_W) + ((rem << FRAC_W) / dm);
        if (q > 64'(cal_max)) q = 64'(cal_max);
        return q[FIELD_W-1:0];
    endfunction

    // Interval halving over 0..max_field. The sign reference is c0 - I, i.e. the
    // residual at the low end of the range.
    function automatic t_field bisect_field(longint cur_q);
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] mid;
        longint    resid;
        longint    sref;
        lo   = '0;
        hi   = 64'(cal_max);
        mid  = '0;
        sref = longint'(cal_coef[0]) - cur_q;
        for (int n = 0; n < MAX_ITER; n++) begin
            mid   = (lo + hi) >> 1;
            resid = horner(mid[FIELD_W-1:0]) - cur_q;
            if (resid == 0 || (hi - lo) < 64'(2 * TOL_LSB)) break;
            if ((resid > 0 && sref > 0) || (resid < 0 && sref < 0)) lo = mid;
            else hi = mid;
        end
        return mid[FIELD_W-1:0];
    endfunction

    function automatic t_solution solve_for(t_cur cur);
        t_solution s;
        longint    cur_q;
        cur_q    = longint'(cur) * 65536;   // Q16.16 -> Q.32
        s.status = STAT_OK;
        if (cal_order == ORDER_NONE) begin
            s.field  = '0;
            s.status = STAT_BAD_ORDER;
        end else if (cal_order <= ORDER_LIN_HI && cal_coef[1] != 0) begin
            s.field = solve_line(cur_q);
        end else begin
            s.field = bisect_field(cur_q);
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit take_break();
        return !calm && ($urandom_range(99, 0) < 14);
    endfunction

    // Coefficient of degree k: mostly scaled down with degree so the curve stays
    // in range over a Q8.16 field, now and then a rail or a full-scale value.
    function automatic t_coef draw_coef(int k);
        logic [63:0] raw;
        t_coef       c;
        int          sh;
        raw = {$urandom(), $urandom()};
        c   = raw[COEF_W-1:0];
        case ($urandom_range(9, 0))
            0: return 48'sh7FFF_FFFF_FFFF;
            1: return 48'sh8000_0000_0000;
            2: return c;
            default: begin
                sh = 8 * k + int'($urandom_range(10, 0));
                if (sh > COEF_W - 1) sh = COEF_W - 1;
                return c >>> sh;
            end
        endcase
    endfunction

    // A current that the curve actually reaches somewhere in range, give or take
    // a couple of LSBs, so the search has a genuine crossing to home in on.
    function automatic t_cur aim_current();
        t_field b;
        longint p;
        b = t_field'($urandom_range(cal_max, 0));
        p = (horner(b) >>> 16) + longint'($urandom_range(4, 0)) - 2;
        if (p > CUR_HI) p = CUR_HI;
        if (p < CUR_LO) p = CUR_LO;
        return t_cur'(p);
    endfunction

    task automatic feed(t_cur v);
        pending.push_back(v);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        if (idx < CFG_ORDER) cal_coef[idx] = val;
        else if (idx == CFG_ORDER) cal_order = val[ORDER_W-1:0];
        else cal_max = val[FIELD_W-1:0];
    endtask

    // Full register load; only called with the block idle.
    task automatic load_setup(t_coef a0, t_coef a1, t_coef a2, t_coef a3, t_coef a4,
                              t_coef a5, logic [ORDER_W-1:0] ord, t_field mf);
        t_coef cs [NUM_COEF];
        cs = '{a0, a1, a2, a3, a4, a5};
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(CFG_COEF_0 + CFG_IDX_W'(k), cs[k]);
        write_reg(CFG_ORDER, COEF_W'(ord));
        write_reg(CFG_MAX, COEF_W'(mf));
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_all_done();
        while (pending.size() != 0 || req_busy || solutions_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Request driver: presents pending[0] and holds it until taken
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_busy) begin
            if (pending.size() != 0 && !take_break()) begin
                req_ch.valid          <= 1'b1;
                req_ch.target_current <= pending[0];
                req_busy = 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= i_rst_n && !take_break();
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each result,
    // and keeps the watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_solution want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                solutions_due.push_back(solve_for(req_ch.target_current));
                pending.delete(0);
                req_busy = 1'b0;
                moved    = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                moved = 1'b1;
                if (solutions_due.size() == 0) begin
                    $display("%0t: result with no request outstanding: expected none, %s %06h %0d",
                             $time, "got field/status", res_ch.field_out, res_ch.status);
                    mismatches++;
                end else begin
                    want = solutions_due.pop_front();
                    if (res_ch.field_out !== want.field) begin
                        $display("%0t: field_out expected %06h, got %06h",
                                 $time, want.field, res_ch.field_out);
                        mismatches++;
                    end
                    if (res_ch.status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, res_ch.status);
                        mismatches++;
                    end
                end
            end
            if (moved) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        t_field             mf;
        logic [ORDER_W-1:0] ord;

        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        req_ch.valid          = 1'b0;
        req_ch.target_current = '0;
        res_ch.ready          = 1'b0;
        req_busy              = 1'b0;
        calm                  = 1'b0;
        mismatches            = 0;
        stall_cycles          = 0;
        foreach (cal_coef[k]) cal_coef[k] = '0;
        cal_order = ORDER_NONE;
        cal_max   = MAX_FIELD_RST;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: order count zero, so every request is refused with
        // a zero field and the bad-order status.
        feed(32'sh0000_0000);
        feed(32'sh7FFF_FFFF);
        feed(32'sh8000_0000);
        wait_all_done();

        // Straight line P = 5.0 + 2.0*B, capped at 100.0: on c0 exactly, below c0
        // (wrong sign), a clean 1.0, far past the cap, and a fractional answer.
        load_setup(48'sh0005_0000_0000, 48'sh0002_0000_0000, '0, '0, '0, '0,
                   ORDER_LIN_LO, 24'h64_0000);
        feed(32'sh0005_0000);
        feed(32'sh0004_0000);
        feed(32'sh0007_0000);
        feed(32'sh7FFF_FFFF);
        feed(32'sh0005_8000);
        wait_all_done();

        // Order two, slope of one negative LSB: quotient overflows the field width.
        load_setup('0, 48'shFFFF_FFFF_FFFF, '0, '0, '0, '0, ORDER_LIN_HI, MAX_FIELD_RST);
        feed(32'shFC18_0000);
        feed(32'sh8000_0000);
        wait_all_done();

        // Identity curve under bisection: in range, at zero, below and above range.
        load_setup('0, 48'sh0001_0000_0000, '0, '0, '0, '0, 3'd3, MAX_FIELD_RST);
        feed(32'sh0064_8000);
        feed(32'sh0000_0000);
        feed(32'shFFFF_0000);
        feed(32'sh012C_0000);
        wait_all_done();

        // Linear order with a zero slope falls back to bisection (B^2 + 2 here).
        load_setup(48'sh0002_0000_0000, '0, 48'sh0001_0000_0000, '0, '0, '0,
                   ORDER_LIN_LO, MAX_FIELD_RST);
        feed(32'sh0006_0000);
        feed(32'sh0001_0000);
        wait_all_done();

        // Order count beyond the coefficient set still bisects on all six.
        load_setup(48'sh0002_0000_0000, '0, 48'sh0001_0000_0000, '0, '0, '0,
                   ORDER_OVER, MAX_FIELD_RST);
        feed(32'sh000B_0000);
        wait_all_done();

        // Empty search interval: answer is zero straight away.
        load_setup(48'sh0002_0000_0000, '0, 48'sh0001_0000_0000, '0, '0, '0,
                   ORDER_FULL, '0);
        feed(32'sh0003_0000);
        wait_all_done();

        // Rails on the top and bottom coefficients: the accumulator saturates.
        load_setup(48'sh8000_0000_0000, '0, '0, '0, '0, 48'sh7FFF_FFFF_FFFF,
                   ORDER_FULL, MAX_FIELD_RST);
        feed(32'sh0000_0000);
        feed(32'sh7FFF_FFFF);
        wait_all_done();

        // Random calibrations, about 25 requests each; one phase runs with no
        // idling at all on either side.
        for (int ph = 0; ph < 20; ph++) begin
            calm = (ph == 7);
            case ($urandom_range(5, 0))
                0: mf = MAX_FIELD_RST;
                1: mf = '0;
                2: mf = t_field'($urandom_range(300, 1));
                default: mf = t_field'($urandom());
            endcase
            case ($urandom_range(9, 0))
                0: ord = ORDER_NONE;
                1: ord = ORDER_LIN_LO;
                2: ord = ORDER_LIN_HI;
                3: ord = ORDER_OVER;
                default: ord = ORDER_W'($urandom_range(6, 3));
            endcase
            load_setup(draw_coef(0), draw_coef(1), draw_coef(2), draw_coef(3),
                       draw_coef(4), draw_coef(5), ord, mf);
            repeat (25) begin
                if ($urandom_range(4, 0) == 0) feed(t_cur'($urandom()));
                else feed(aim_current());
            end
            wait_all_done();
        end
        calm = 1'b0;

        // Quiet tail: anything arriving now has no request behind it.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && solutions_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/pib_pkg.sv
hdl/pib_if.sv
hdl/pib_mul.sv
hdl/pib_div.sv
hdl/polynomial_inverse_bisection.sv
dv/polynomial_inverse_bisection_tb.sv
